// ===== rtl/ctl_pkg.sv =====
package ctl_pkg;

  // word format of every word-wide field and register
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int CFG_ADDR_BITS = 5;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_GROUP = 2'd1,
    ST_NO_PART   = 2'd2,
    ST_NO_DATA   = 2'd3
  } status_t;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_SPEED_SCALE     = 3'd0;
  localparam logic [2:0] REG_COLLISION_SHARE = 3'd1;
  localparam logic [2:0] REG_TRANSIT_SHARE   = 3'd2;
  localparam logic [2:0] REG_THREE_DIM       = 3'd3;
  localparam logic [2:0] REG_MIN_LEVEL       = 3'd4;

  localparam word_t ONE_FX = word_t'(1) << FRAC_BITS;

  typedef struct packed {
    logic  in_group;
    logic  has_particles;
    word_t temperature;
    word_t free_path;
    word_t u_square;
    word_t v_square;
    word_t w_square;
    word_t size_x;
    word_t size_y;
    word_t size_z;
    logic  last_cell;
  } in_t;

  typedef struct packed {
    word_t   cell_dt;
    status_t dt_status;
    logic    last_out;
  } out_t;

  // control tag that travels down the pipeline with each cell
  typedef struct packed {
    logic    valid;
    logic    last;
    status_t status;
    logic    data_ok;
  } tag_t;

endpackage

// ===== rtl/ctl_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module ctl_sqrt #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic [2*W-1:0] rad,
  output logic [W-1:0]   root
);

  localparam int RW = W + 3;

  logic [RW-1:0]  rem_r   [W];
  logic [W-1:0]   root_r  [W];
  logic [2*W-1:0] rad_r   [W];
  logic [RW-1:0]  rem_nxt [W];
  logic [W-1:0]   root_nxt[W];
  logic [2*W-1:0] rad_nxt [W];
  logic [RW-1:0]  rem_in  [W];
  logic [W-1:0]   root_in [W];
  logic [2*W-1:0] rad_in  [W];
  logic [RW-1:0]  sh      [W];
  logic [RW-1:0]  trial   [W];

  for (genvar i = 0; i < W; i++) begin : g_st
    if (i == 0) begin : g_first
      assign rem_in[i]  = '0;
      assign root_in[i] = '0;
      assign rad_in[i]  = rad;
    end else begin : g_next
      assign rem_in[i]  = rem_r[i-1];
      assign root_in[i] = root_r[i-1];
      assign rad_in[i]  = rad_r[i-1];
    end

    // bring down two radicand bits, try root bit = 1
    assign sh[i]    = {rem_in[i][RW-3:0], rad_in[i][2*W-1 -: 2]};
    assign trial[i] = {1'b0, root_in[i], 2'b01};

    always_comb begin
      if (sh[i] >= trial[i]) begin
        rem_nxt[i]  = sh[i] - trial[i];
        root_nxt[i] = {root_in[i][W-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = sh[i];
        root_nxt[i] = {root_in[i][W-2:0], 1'b0};
      end
      rad_nxt[i] = {rad_in[i][2*W-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= rem_nxt[i];
      root_r[i] <= root_nxt[i];
      rad_r[i]  <= rad_nxt[i];
    end
  end

  assign root = root_r[W-1];

endmodule

// ===== rtl/ctl_div.sv =====
// Pipelined restoring divider, 2W / W bits, one quotient bit per stage;
// quotient saturates to all ones on overflow.
module ctl_div #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic [2*W-1:0] num,
  input  logic [W-1:0]   den,
  output logic [W-1:0]   quo
);

  logic [W-1:0] rem_r  [W];
  logic [W-1:0] lo_r   [W];
  logic [W-1:0] den_r  [W];
  logic [W-1:0] q_r    [W];
  logic         sat_r  [W];
  logic [W-1:0] rem_nxt[W];
  logic [W-1:0] q_nxt  [W];
  logic [W-1:0] rem_in [W];
  logic [W-1:0] lo_in  [W];
  logic [W-1:0] den_in [W];
  logic [W-1:0] q_in   [W];
  logic         sat_in [W];
  logic [W:0]   sh     [W];

  for (genvar i = 0; i < W; i++) begin : g_st
    if (i == 0) begin : g_first
      assign rem_in[i] = num[2*W-1:W];
      assign lo_in[i]  = num[W-1:0];
      assign den_in[i] = den;
      assign q_in[i]   = '0;
      assign sat_in[i] = (num[2*W-1:W] >= den);
    end else begin : g_next
      assign rem_in[i] = rem_r[i-1];
      assign lo_in[i]  = lo_r[i-1];
      assign den_in[i] = den_r[i-1];
      assign q_in[i]   = q_r[i-1];
      assign sat_in[i] = sat_r[i-1];
    end

    // shift in next dividend bit, subtract if it fits
    assign sh[i] = {rem_in[i], lo_in[i][W-1]};

    always_comb begin
      if (sh[i] >= {1'b0, den_in[i]}) begin
        rem_nxt[i] = W'(sh[i] - {1'b0, den_in[i]});
        q_nxt[i]   = {q_in[i][W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = sh[i][W-1:0];
        q_nxt[i]   = {q_in[i][W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= rem_nxt[i];
      q_r[i]   <= q_nxt[i];
      lo_r[i]  <= {lo_in[i][W-2:0], 1'b0};
      den_r[i] <= den_in[i];
      sat_r[i] <= sat_in[i];
    end
  end

  assign quo = sat_r[W-1] ? '1 : q_r[W-1];

endmodule

// ===== rtl/cell_timestep_limit.sv =====
// Desired timestep per grid cell.
// Input channel: a cell transaction is taken on each clock edge with start
// high and busy low; busy is always low, so one cell may enter every cycle.
// Result channel: out_valid is high for one cycle with out_data holding
// cell_dt, dt_status and last_out; results leave in input order.
// Path: a product register, the square root pipes (one root bit per stage),
// the seven divider pipes (one quotient bit per stage), the minimum tree
// registers and the output register. Throughput is one cell per cycle,
// set by the fully pipelined root and divider units.
// Configuration: APB write at byte address 4*index, pready always high;
// the user must write registers only while no cell is in flight; the
// block itself does not enforce this. Reset (rst_n low, synchronous)
// clears all valid bits and loads register defaults. The receiver cannot
// stall: out_valid is a strobe only.
module cell_timestep_limit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  ctl_pkg::in_t                       in_data,
  output logic                               out_valid,
  output ctl_pkg::out_t                      out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ctl_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int W  = ctl_pkg::WORD_BITS;
  localparam int F  = ctl_pkg::FRAC_BITS;
  localparam int DW = 2 * W;

  // configuration registers
  ctl_pkg::word_t speed_scale_r, collision_share_r, transit_share_r, min_level_r;
  logic           three_dim_r;
  logic [2:0]     reg_idx;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_scale_r     <= ctl_pkg::ONE_FX;
      collision_share_r <= ctl_pkg::ONE_FX;
      transit_share_r   <= ctl_pkg::ONE_FX;
      three_dim_r       <= 1'b1;
      min_level_r       <= ctl_pkg::word_t'(1);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        ctl_pkg::REG_SPEED_SCALE:     speed_scale_r     <= W'(pwdata);
        ctl_pkg::REG_COLLISION_SHARE: collision_share_r <= W'(pwdata);
        ctl_pkg::REG_TRANSIT_SHARE:   transit_share_r   <= W'(pwdata);
        ctl_pkg::REG_THREE_DIM:       three_dim_r       <= pwdata[0];
        ctl_pkg::REG_MIN_LEVEL:       min_level_r       <= W'(pwdata);
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      ctl_pkg::REG_SPEED_SCALE:     prdata = 32'(speed_scale_r);
      ctl_pkg::REG_COLLISION_SHARE: prdata = 32'(collision_share_r);
      ctl_pkg::REG_TRANSIT_SHARE:   prdata = 32'(transit_share_r);
      ctl_pkg::REG_THREE_DIM:       prdata = {31'd0, three_dim_r};
      ctl_pkg::REG_MIN_LEVEL:       prdata = 32'(min_level_r);
      default:                      prdata = '0;
    endcase
  end

  // stage P: products, radicands, early status
  ctl_pkg::tag_t  tag_p_nxt, tag_p_r;
  logic [DW-1:0]  spd_rad_r, col_prod_r;
  logic [DW-1:0]  tr_prod_r [3];
  logic [DW-1:0]  mag_rad_r [3];
  logic [W+1:0]   sq_sum;
  ctl_pkg::word_t sq_in   [3];
  ctl_pkg::word_t size_in [3];

  assign sq_in[0]   = in_data.u_square;
  assign sq_in[1]   = in_data.v_square;
  assign sq_in[2]   = in_data.w_square;
  assign size_in[0] = in_data.size_x;
  assign size_in[1] = in_data.size_y;
  assign size_in[2] = in_data.size_z;
  assign sq_sum = (W+2)'(in_data.u_square) + (W+2)'(in_data.v_square)
                + (W+2)'(in_data.w_square);

  always_comb begin
    tag_p_nxt.valid = start && !busy;
    tag_p_nxt.last  = in_data.last_cell;
    if (!in_data.in_group) begin
      tag_p_nxt.status = ctl_pkg::ST_NOT_GROUP;
    end else if (!in_data.has_particles) begin
      tag_p_nxt.status = ctl_pkg::ST_NO_PART;
    end else begin
      tag_p_nxt.status = ctl_pkg::ST_OK;
    end
    tag_p_nxt.data_ok = (in_data.free_path > min_level_r)
                     && (sq_sum > (W+2)'(min_level_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_p_r <= '0;
    end else begin
      tag_p_r <= tag_p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    spd_rad_r  <= DW'(speed_scale_r) * DW'(in_data.temperature);
    col_prod_r <= DW'(collision_share_r) * DW'(in_data.free_path);
    for (int k = 0; k < 3; k++) begin
      tr_prod_r[k] <= DW'(transit_share_r) * DW'(size_in[k]);
      mag_rad_r[k] <= DW'(sq_in[k]) << F;
    end
  end

  // square roots: speed and three velocity magnitudes
  ctl_pkg::word_t speed;
  ctl_pkg::word_t mag [3];

  ctl_sqrt #(.W(W)) u_sqrt_spd (.clk(clk), .rad(spd_rad_r), .root(speed));

  for (genvar k = 0; k < 3; k++) begin : g_mag
    ctl_sqrt #(.W(W)) u_sqrt_mag (.clk(clk), .rad(mag_rad_r[k]), .root(mag[k]));
  end

  // delay lines alongside the root pipes
  ctl_pkg::tag_t tag_s_r [W];
  logic [DW-1:0] col_s_r [W];
  logic [DW-1:0] tr_s_r  [3][W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < W; i++) tag_s_r[i] <= '0;
    end else begin
      tag_s_r[0] <= tag_p_r;
      for (int i = 1; i < W; i++) tag_s_r[i] <= tag_s_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    col_s_r[0] <= col_prod_r;
    for (int k = 0; k < 3; k++) tr_s_r[k][0] <= tr_prod_r[k];
    for (int i = 1; i < W; i++) begin
      col_s_r[i] <= col_s_r[i-1];
      for (int k = 0; k < 3; k++) tr_s_r[k][i] <= tr_s_r[k][i-1];
    end
  end

  // sufficiency check and divider operands
  ctl_pkg::tag_t  tag_q;
  ctl_pkg::tag_t  tag_s_last;
  ctl_pkg::word_t vel_den [3];
  logic [3:0]     skip_q;

  assign tag_s_last = tag_s_r[W-1];

  always_comb begin
    tag_q = tag_s_last;
    if (tag_s_last.status == ctl_pkg::ST_OK
        && !(tag_s_last.data_ok && speed > min_level_r)) begin
      tag_q.status = ctl_pkg::ST_NO_DATA;
    end
    for (int k = 0; k < 3; k++) begin
      vel_den[k] = (mag[k] == '0) ? ctl_pkg::word_t'(1) : mag[k];
    end
    // bits: x vel, y vel, z vel, z speed term
    skip_q[0] = (mag[0] == '0);
    skip_q[1] = (mag[1] == '0);
    skip_q[2] = (mag[2] == '0) || !three_dim_r;
    skip_q[3] = !three_dim_r;
  end

  ctl_pkg::word_t q_col;
  ctl_pkg::word_t q_vel [3];
  ctl_pkg::word_t q_spd [3];

  ctl_div #(.W(W)) u_div_col (.clk(clk), .num(col_s_r[W-1]), .den(speed), .quo(q_col));

  for (genvar k = 0; k < 3; k++) begin : g_div
    ctl_div #(.W(W)) u_div_vel (
      .clk(clk), .num(tr_s_r[k][W-1]), .den(vel_den[k]), .quo(q_vel[k]));
    ctl_div #(.W(W)) u_div_spd (
      .clk(clk), .num(tr_s_r[k][W-1]), .den(speed), .quo(q_spd[k]));
  end

  // delay lines alongside the divider pipes
  ctl_pkg::tag_t tag_d_r  [W];
  logic [3:0]    skip_d_r [W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < W; i++) tag_d_r[i] <= '0;
    end else begin
      tag_d_r[0] <= tag_q;
      for (int i = 1; i < W; i++) tag_d_r[i] <= tag_d_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    skip_d_r[0] <= skip_q;
    for (int i = 1; i < W; i++) skip_d_r[i] <= skip_d_r[i-1];
  end

  // masked terms: a skipped term becomes all ones, neutral for the minimum
  ctl_pkg::word_t t_vx, t_vy, t_vz, t_sz;

  assign t_vx = skip_d_r[W-1][0] ? '1 : q_vel[0];
  assign t_vy = skip_d_r[W-1][1] ? '1 : q_vel[1];
  assign t_vz = skip_d_r[W-1][2] ? '1 : q_vel[2];
  assign t_sz = skip_d_r[W-1][3] ? '1 : q_spd[2];

  // minimum tree, levels one and two
  ctl_pkg::tag_t  tag_m1_r, tag_m2_r;
  ctl_pkg::word_t m1_r [4];
  ctl_pkg::word_t m2_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_m1_r <= '0;
      tag_m2_r <= '0;
    end else begin
      tag_m1_r <= tag_d_r[W-1];
      tag_m2_r <= tag_m1_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_r[0] <= (q_col < t_vx) ? q_col : t_vx;
    m1_r[1] <= (q_spd[0] < t_vy) ? q_spd[0] : t_vy;
    m1_r[2] <= (q_spd[1] < t_vz) ? q_spd[1] : t_vz;
    m1_r[3] <= t_sz;
    m2_r[0] <= (m1_r[0] < m1_r[1]) ? m1_r[0] : m1_r[1];
    m2_r[1] <= (m1_r[2] < m1_r[3]) ? m1_r[2] : m1_r[3];
  end

  // final minimum and output register
  ctl_pkg::out_t  out_nxt, out_r;
  logic           out_valid_r;
  ctl_pkg::word_t dt_min;

  assign dt_min = (m2_r[0] < m2_r[1]) ? m2_r[0] : m2_r[1];

  always_comb begin
    out_nxt.dt_status = tag_m2_r.status;
    out_nxt.last_out  = tag_m2_r.last;
    out_nxt.cell_dt   = (tag_m2_r.status == ctl_pkg::ST_OK) ? dt_min : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tag_m2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int LATENCY = 2 * ctl_pkg::WORD_BITS + 4;
  localparam int RANDOM_CELLS = 1500;

  // mismatch counter and report task
  int errors = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
  endtask

  // reference timestep computation, held in its own copy of the registers
  class dt_scoreboard;
    bit [31:0] speed_scale = 32'h10000;
    bit [31:0] collision_share = 32'h10000;
    bit [31:0] transit_share = 32'h10000;
    bit        three_dim = 1'b1;
    bit [31:0] min_level = 32'd1;
    ctl_pkg::out_t pending[$];

    function automatic bit [31:0] isqrt(bit [63:0] n);
      bit [31:0] r;
      bit [31:0] c;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
        c = r | (32'd1 << b);
        if ({32'd0, c} * {32'd0, c} <= n) r = c;
      end
      return r;
    endfunction

    function automatic bit [31:0] sat_div(bit [63:0] n, bit [31:0] d);
      bit [63:0] q;
      q = n / d;
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic ctl_pkg::out_t cell_timestep(ctl_pkg::in_t c);
      ctl_pkg::out_t r;
      bit [31:0] speed, mag, lim;
      bit [33:0] sum;
      bit [63:0] p;
      bit [31:0] sq[3];
      bit [31:0] sz[3];
      r = '0;
      r.last_out = c.last_cell;
      sq = '{c.u_square, c.v_square, c.w_square};
      sz = '{c.size_x, c.size_y, c.size_z};
      if (!c.in_group) r.dt_status = ctl_pkg::ST_NOT_GROUP;
      else if (!c.has_particles) r.dt_status = ctl_pkg::ST_NO_PART;
      else begin
        speed = isqrt({32'd0, speed_scale} * {32'd0, c.temperature});
        sum = {2'b0, sq[0]} + {2'b0, sq[1]} + {2'b0, sq[2]};
        if (!(speed > min_level && c.free_path > min_level && sum > {2'b0, min_level})) begin
          r.dt_status = ctl_pkg::ST_NO_DATA;
        end else begin
          r.dt_status = ctl_pkg::ST_OK;
          lim = sat_div({32'd0, collision_share} * {32'd0, c.free_path}, speed);
          for (int k = 0; k < (three_dim ? 3 : 2); k++) begin
            mag = isqrt({16'd0, sq[k], 16'd0});
            p = {32'd0, transit_share} * {32'd0, sz[k]};
            if (mag != 0 && sat_div(p, mag) < lim) lim = sat_div(p, mag);
            if (sat_div(p, speed) < lim) lim = sat_div(p, speed);
          end
          r.cell_dt = lim;
        end
      end
      return r;
    endfunction

    function void set_reg(logic [2:0] idx, bit [31:0] v);
      case (idx)
        ctl_pkg::REG_SPEED_SCALE:     speed_scale = v;
        ctl_pkg::REG_COLLISION_SHARE: collision_share = v;
        ctl_pkg::REG_TRANSIT_SHARE:   transit_share = v;
        ctl_pkg::REG_THREE_DIM:       three_dim = v[0];
        ctl_pkg::REG_MIN_LEVEL:       min_level = v;
        default: ;
      endcase
    endfunction

    function void note_cell(ctl_pkg::in_t c);
      pending.push_back(cell_timestep(c));
    endfunction

    task check_result(ctl_pkg::out_t got);
      ctl_pkg::out_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", got, 0);
        return;
      end
      want = pending.pop_front();
      if (got.cell_dt !== want.cell_dt) report_mismatch("cell_dt", got.cell_dt, want.cell_dt);
      if (got.dt_status !== want.dt_status)
        report_mismatch("dt_status", got.dt_status, want.dt_status);
      if (got.last_out !== want.last_out)
        report_mismatch("last_out", got.last_out, want.last_out);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ctl_pkg::in_t in_data = '0;
  logic out_valid;
  ctl_pkg::out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ctl_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dt_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cell_timestep_limit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // result side: every strobe is one transaction
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // register write, setup then access phase
  task automatic write_reg(logic [2:0] idx, bit [31:0] v);
    paddr = ctl_pkg::CFG_ADDR_BITS'(idx) << 2;
    pwdata = v;
    pwrite = 1'b1;
    psel = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // send one cell transaction; called at a falling edge
  task automatic send_cell(ctl_pkg::in_t c);
    in_data = c;
    start = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_cell(c);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    start = 1'b0;
    if (r < 10) repeat ($urandom_range(1, 3)) @(negedge clk);
    else if (r < 12) repeat ($urandom_range(20, 90)) @(negedge clk);
  endtask

  function automatic bit [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(32'h8000, 32'h4_0000);
      3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic ctl_pkg::in_t rand_cell();
    ctl_pkg::in_t c;
    c.in_group = ($urandom_range(0, 9) != 0);
    c.has_particles = ($urandom_range(0, 9) != 0);
    c.temperature = rand_word();
    c.free_path = rand_word();
    c.u_square = rand_word();
    c.v_square = rand_word();
    c.w_square = ($urandom_range(0, 7) == 0) ? 32'd0 : rand_word();
    c.size_x = rand_word();
    c.size_y = rand_word();
    c.size_z = rand_word();
    c.last_cell = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic ctl_pkg::in_t plain_cell();
    ctl_pkg::in_t c;
    c = '0;
    c.in_group = 1'b1;
    c.has_particles = 1'b1;
    c.temperature = ctl_pkg::ONE_FX;
    c.free_path = ctl_pkg::ONE_FX;
    c.u_square = ctl_pkg::ONE_FX;
    c.v_square = ctl_pkg::ONE_FX;
    c.w_square = ctl_pkg::ONE_FX;
    c.size_x = ctl_pkg::ONE_FX;
    c.size_y = ctl_pkg::ONE_FX;
    c.size_z = ctl_pkg::ONE_FX;
    return c;
  endfunction

  initial begin
    ctl_pkg::in_t c;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: status priority, thresholds, zero magnitudes, saturation
    c = plain_cell(); send_cell(c);
    c.in_group = 1'b0; c.has_particles = 1'b0; send_cell(c);
    c = plain_cell(); c.has_particles = 1'b0; c.last_cell = 1'b1; send_cell(c);
    c = plain_cell(); c.temperature = 32'd0; send_cell(c);
    c = plain_cell(); c.free_path = 32'd1; send_cell(c);
    c = plain_cell(); c.u_square = 1; c.v_square = 0; c.w_square = 0; send_cell(c);
    c = plain_cell(); c.u_square = 2; c.v_square = 0; c.w_square = 0; send_cell(c);
    c = plain_cell(); c.v_square = 0; c.w_square = 0; send_cell(c);
    c = plain_cell(); c.u_square = '1; c.v_square = '1; c.w_square = '1; send_cell(c);
    c = plain_cell(); c.free_path = '1; c.size_x = '1; c.size_y = '1; c.size_z = '1;
    c.temperature = 32'd2; c.u_square = 0; c.v_square = 0; send_cell(c);
    c = plain_cell(); c.temperature = '1; c.size_x = 32'd1; c.last_cell = 1'b1; send_cell(c);
    c = '1; send_cell(c);
    c = '0; send_cell(c);
    start = 1'b0;
    drain();

    // several register settings, extremes included
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ;
        1: begin
          write_reg(ctl_pkg::REG_THREE_DIM, 32'd0);
          write_reg(ctl_pkg::REG_MIN_LEVEL, 32'd0);
          write_reg(ctl_pkg::REG_SPEED_SCALE, '1);
        end
        2: begin
          write_reg(ctl_pkg::REG_COLLISION_SHARE, '1);
          write_reg(ctl_pkg::REG_TRANSIT_SHARE, '1);
          write_reg(ctl_pkg::REG_MIN_LEVEL, '1);
        end
        3: begin
          write_reg(ctl_pkg::REG_THREE_DIM, 32'hFFFF_FFFF);
          write_reg(ctl_pkg::REG_MIN_LEVEL, 32'h100);
          write_reg(ctl_pkg::REG_SPEED_SCALE, 32'd0);
          write_reg(ctl_pkg::REG_COLLISION_SHARE, 32'd0);
          write_reg(ctl_pkg::REG_TRANSIT_SHARE, 32'd0);
        end
        default: begin
          write_reg(ctl_pkg::REG_SPEED_SCALE, rand_word());
          write_reg(ctl_pkg::REG_COLLISION_SHARE, rand_word());
          write_reg(ctl_pkg::REG_TRANSIT_SHARE, rand_word());
          write_reg(ctl_pkg::REG_THREE_DIM, $urandom);
          write_reg(ctl_pkg::REG_MIN_LEVEL, $urandom_range(0, 32'h2_0000));
        end
      endcase
      for (int i = 0; i < RANDOM_CELLS / 6; i++) begin
        send_cell(rand_cell());
        if (i % 100 < 30) idle_gap();
      end
      start = 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("cell_timestep_limit verification clean");
    end else begin
      $display("cell_timestep_limit verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("cell_timestep_limit verification failed");
    $finish;
  end

endmodule
